// ===== hw/rtl/rstu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstu_pkg
// Types and constants shared by the radix string to unsigned converter.
// ----------------------------------------------------------------------------
package rstu_pkg;

  localparam int unsigned CHAR_BITS     = 21;
  localparam int unsigned BASE_BITS     = 6;
  localparam int unsigned STATUS_BITS   = 2;
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  // register indexes (paddr[2])
  localparam logic REG_RADIX = 1'b0;

  localparam logic [BASE_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_AUTO   = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_MIN    = 6'd2;
  localparam logic [BASE_BITS-1:0] BASE_MAX    = 6'd36;
  localparam logic [BASE_BITS-1:0] BASE_HEX    = 6'd16;
  localparam logic [BASE_BITS-1:0] BASE_OCT    = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC    = 6'd10;

  // status codes
  localparam logic [STATUS_BITS-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_RANGE  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_NOCONV = 2'd2;

  // character codes
  localparam logic [CHAR_BITS-1:0] CH_TAB    = 21'd9;
  localparam logic [CHAR_BITS-1:0] CH_CR     = 21'd13;
  localparam logic [CHAR_BITS-1:0] CH_SPACE  = 21'd32;
  localparam logic [CHAR_BITS-1:0] CH_PLUS   = 21'd43;
  localparam logic [CHAR_BITS-1:0] CH_MINUS  = 21'd45;
  localparam logic [CHAR_BITS-1:0] CH_0      = 21'd48;
  localparam logic [CHAR_BITS-1:0] CH_9      = 21'd57;
  localparam logic [CHAR_BITS-1:0] CH_UA     = 21'd65;
  localparam logic [CHAR_BITS-1:0] CH_UX     = 21'd88;
  localparam logic [CHAR_BITS-1:0] CH_UZ     = 21'd90;
  localparam logic [CHAR_BITS-1:0] CH_LA     = 21'd97;
  localparam logic [CHAR_BITS-1:0] CH_LX     = 21'd120;
  localparam logic [CHAR_BITS-1:0] CH_LZ     = 21'd122;
  localparam logic [CHAR_BITS-1:0] UPPER_BIAS = 21'd55;  // 'A' - 10
  localparam logic [CHAR_BITS-1:0] LOWER_BIAS = 21'd87;  // 'a' - 10

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_SPACE  = 6'b000010,
    PH_SIGNED = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_PREFIX = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_e;

  typedef struct packed {
    logic                 is_space;
    logic                 is_minus;
    logic                 is_plus;
    logic                 is_zero;
    logic                 is_x;
    logic                 is_alnum;
    logic [BASE_BITS-1:0] digit;
  } char_class_t;

endpackage

// ===== hw/rtl/rstu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstu_in_if / rstu_out_if
// Valid/ready channels for characters in and conversion results out.
// ----------------------------------------------------------------------------
interface rstu_in_if;
  logic                           valid;
  logic                           ready;
  logic [rstu_pkg::CHAR_BITS-1:0] char_code;
  logic                           start_req;

  modport source (output valid, char_code, start_req, input ready);
  modport sink (input valid, char_code, start_req, output ready);
endinterface

interface rstu_out_if #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned COUNT_BITS = 16
);
  logic                             valid;
  logic                             ready;
  logic [VALUE_BITS-1:0]            value;
  logic [rstu_pkg::STATUS_BITS-1:0] status;
  logic [COUNT_BITS-1:0]            chars_consumed;

  modport source (output valid, value, status, chars_consumed, input ready);
  modport sink (input valid, value, status, chars_consumed, output ready);
endinterface

// ===== hw/rtl/rstu_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstu_cfg
// APB register file holding the radix register.
// ----------------------------------------------------------------------------
module rstu_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rstu_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [rstu_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [rstu_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output logic [rstu_pkg::BASE_BITS-1:0]      radix_o
);

  logic                              wr_en;
  logic [rstu_pkg::BASE_BITS-1:0]    radix_q;
  logic [rstu_pkg::BASE_BITS-1:0]    radix_d;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == rstu_pkg::REG_RADIX);

  always_comb begin
    radix_d = radix_q;
    if (wr_en) begin
      radix_d = pwdata[rstu_pkg::BASE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rstu_pkg::RADIX_RESET;
    end else begin
      radix_q <= radix_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == rstu_pkg::REG_RADIX) begin
      prdata = {{(rstu_pkg::CFG_DATA_BITS - rstu_pkg::BASE_BITS){1'b0}}, radix_q};
    end
  end

  assign radix_o = radix_q;

endmodule

// ===== hw/rtl/rstu_char_class.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstu_char_class
// Character decode: whitespace, sign, zero, x, and alphanumeric digit value.
// ----------------------------------------------------------------------------
module rstu_char_class (
  input  logic [rstu_pkg::CHAR_BITS-1:0] char_code_i,
  output rstu_pkg::char_class_t          cls_o
);

  always_comb begin
    cls_o          = '0;
    cls_o.is_space = (char_code_i == rstu_pkg::CH_SPACE) ||
                     ((char_code_i >= rstu_pkg::CH_TAB) && (char_code_i <= rstu_pkg::CH_CR));
    cls_o.is_minus = (char_code_i == rstu_pkg::CH_MINUS);
    cls_o.is_plus  = (char_code_i == rstu_pkg::CH_PLUS);
    cls_o.is_zero  = (char_code_i == rstu_pkg::CH_0);
    cls_o.is_x     = (char_code_i == rstu_pkg::CH_LX) || (char_code_i == rstu_pkg::CH_UX);
    if ((char_code_i >= rstu_pkg::CH_0) && (char_code_i <= rstu_pkg::CH_9)) begin
      cls_o.is_alnum = 1'b1;
      cls_o.digit    = rstu_pkg::BASE_BITS'(char_code_i - rstu_pkg::CH_0);
    end else if ((char_code_i >= rstu_pkg::CH_UA) && (char_code_i <= rstu_pkg::CH_UZ)) begin
      cls_o.is_alnum = 1'b1;
      cls_o.digit    = rstu_pkg::BASE_BITS'(char_code_i - rstu_pkg::UPPER_BIAS);
    end else if ((char_code_i >= rstu_pkg::CH_LA) && (char_code_i <= rstu_pkg::CH_LZ)) begin
      cls_o.is_alnum = 1'b1;
      cls_o.digit    = rstu_pkg::BASE_BITS'(char_code_i - rstu_pkg::LOWER_BIAS);
    end
  end

endmodule

// ===== hw/rtl/rstu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstu_core
// Parse state, digit accumulate step and result register.
// ----------------------------------------------------------------------------
module rstu_core #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rstu_pkg::BASE_BITS-1:0] radix_i,
  input  logic                           item_vld_i,
  input  logic                           start_i,
  input  rstu_pkg::char_class_t          cls_i,
  output logic                           adv_o,
  rstu_out_if.source                     out_o
);

  localparam int unsigned BB        = rstu_pkg::BASE_BITS;
  localparam int unsigned PROD_BITS = VALUE_BITS + BB;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  rstu_pkg::phase_e        phase_q, phase_d, ph_cur;
  logic [VALUE_BITS-1:0]   acc_q, acc_d, acc_cur;
  logic                    neg_q, neg_d, neg_cur;
  logic                    ovf_q, ovf_d, ovf_cur;
  logic                    any_q, any_d, any_cur;
  logic [BB-1:0]           base_q, base_d, base_cur;
  logic [COUNT_BITS-1:0]   pos_q, pos_d, pos_cur, pos_inc, pos_dec;

  logic                    first_go, take_go, digit_ok, any_t;
  logic [BB-1:0]           take_base;
  logic [PROD_BITS-1:0]    prod;

  logic                          res_vld;
  logic [VALUE_BITS-1:0]         res_value;
  logic [rstu_pkg::STATUS_BITS-1:0] res_status;
  logic [COUNT_BITS-1:0]         res_count;

  logic                          out_vld_q;
  logic [VALUE_BITS-1:0]         value_q;
  logic [rstu_pkg::STATUS_BITS-1:0] status_q;
  logic [COUNT_BITS-1:0]         count_q;

  assign adv_o = item_vld_i && (!out_vld_q || out_o.ready);

  // start item restarts the parse with its own character
  always_comb begin
    ph_cur   = start_i ? rstu_pkg::PH_SPACE : phase_q;
    acc_cur  = start_i ? '0 : acc_q;
    neg_cur  = start_i ? 1'b0 : neg_q;
    ovf_cur  = start_i ? 1'b0 : ovf_q;
    any_cur  = start_i ? 1'b0 : any_q;
    base_cur = start_i ? '0 : base_q;
    pos_cur  = start_i ? '0 : pos_q;
    pos_inc  = (pos_cur == CountMax) ? pos_cur : pos_cur + 1'b1;
    pos_dec  = (pos_cur == CountMax) ? pos_cur : pos_cur - 1'b1;
  end

  always_comb begin
    phase_d    = ph_cur;
    acc_d      = acc_cur;
    neg_d      = neg_cur;
    ovf_d      = ovf_cur;
    any_d      = any_cur;
    base_d     = base_cur;
    pos_d      = pos_cur;
    first_go   = 1'b0;
    take_go    = 1'b0;
    any_t      = any_cur;
    take_base  = base_cur;
    digit_ok   = 1'b0;
    prod       = '0;
    res_vld    = 1'b0;
    res_value  = '0;
    res_status = rstu_pkg::STATUS_OK;
    res_count  = '0;

    case (ph_cur)
      rstu_pkg::PH_SPACE: begin
        if (cls_i.is_space) begin
          pos_d = pos_inc;
        end else if (cls_i.is_minus || cls_i.is_plus) begin
          neg_d   = cls_i.is_minus;
          phase_d = rstu_pkg::PH_SIGNED;
          pos_d   = pos_inc;
        end else begin
          first_go = 1'b1;
        end
      end
      rstu_pkg::PH_SIGNED: begin
        first_go = 1'b1;
      end
      rstu_pkg::PH_ZERO: begin
        if (cls_i.is_x) begin
          base_d  = rstu_pkg::BASE_HEX;
          phase_d = rstu_pkg::PH_PREFIX;
          pos_d   = pos_inc;
        end else begin
          take_base = (radix_i == rstu_pkg::BASE_AUTO) ? rstu_pkg::BASE_OCT
                                                        : rstu_pkg::BASE_HEX;
          any_t     = 1'b1;
          take_go   = 1'b1;
        end
      end
      rstu_pkg::PH_PREFIX: begin
        if (cls_i.is_alnum && (cls_i.digit < rstu_pkg::BASE_HEX)) begin
          take_go = 1'b1;
        end else begin
          res_vld    = 1'b1;
          res_status = rstu_pkg::STATUS_OK;
          res_count  = pos_dec;
        end
      end
      rstu_pkg::PH_DIGITS: begin
        take_go = 1'b1;
      end
      default: begin
      end
    endcase

    if (first_go) begin
      if (((radix_i == rstu_pkg::BASE_AUTO) || (radix_i == rstu_pkg::BASE_HEX)) &&
          cls_i.is_zero) begin
        phase_d = rstu_pkg::PH_ZERO;
        pos_d   = pos_inc;
      end else begin
        take_base = (radix_i == rstu_pkg::BASE_AUTO) ? rstu_pkg::BASE_DEC : radix_i;
        if ((take_base < rstu_pkg::BASE_MIN) || (take_base > rstu_pkg::BASE_MAX)) begin
          base_d     = take_base;
          res_vld    = 1'b1;
          res_status = rstu_pkg::STATUS_NOCONV;
        end else begin
          take_go = 1'b1;
        end
      end
    end

    if (take_go) begin
      base_d   = take_base;
      phase_d  = rstu_pkg::PH_DIGITS;
      any_d    = any_t;
      digit_ok = cls_i.is_alnum && (cls_i.digit < take_base);
      prod     = ({{BB{1'b0}}, acc_cur} * {{VALUE_BITS{1'b0}}, take_base}) +
                 {{VALUE_BITS{1'b0}}, cls_i.digit};
      if (digit_ok) begin
        any_d = 1'b1;
        pos_d = pos_inc;
        if (ovf_cur || (|prod[PROD_BITS-1:VALUE_BITS])) begin
          ovf_d = 1'b1;
        end else begin
          acc_d = prod[VALUE_BITS-1:0];
        end
      end else begin
        res_vld = 1'b1;
        if (ovf_cur) begin
          res_value  = '1;
          res_status = rstu_pkg::STATUS_RANGE;
          res_count  = pos_cur;
        end else if (!any_t) begin
          res_status = rstu_pkg::STATUS_NOCONV;
        end else begin
          res_value  = neg_cur ? ('0 - acc_cur) : acc_cur;
          res_status = rstu_pkg::STATUS_OK;
          res_count  = pos_cur;
        end
      end
    end

    if (res_vld) begin
      phase_d = rstu_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rstu_pkg::PH_IDLE;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      any_q   <= 1'b0;
      base_q  <= '0;
      pos_q   <= '0;
    end else if (adv_o) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
      any_q   <= any_d;
      base_q  <= base_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_o && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_vld) begin
      value_q  <= res_value;
      status_q <= res_status;
      count_q  <= res_count;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.value          = value_q;
  assign out_o.status         = status_q;
  assign out_o.chars_consumed = count_q;

endmodule

// ===== hw/rtl/radix_string_to_unsigned.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_string_to_unsigned
// Streaming string to unsigned integer converter with APB radix register.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      beat contents
//  in_i      in   valid/ready    char_code, start_req
//  out_o     out  valid/ready    value, status, chars_consumed
//  apb       in   psel/penable   radix register at byte address 0
//
//  One beat per cycle sustained while out_o is not stalled; the terminating
//  character goes to the input register, its result to the result register.
//  Digit step: one radix multiply, add and overflow check per unstalled cycle.
//  Reset clears the parse state and empties both registers; radix resets to 10.
//  A stalled result holds the result register; the input register keeps
//  accepting until it also fills.
// ----------------------------------------------------------------------------
module radix_string_to_unsigned #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rstu_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [rstu_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [rstu_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready,
  rstu_in_if.sink                            in_i,
  rstu_out_if.source                         out_o
);

  logic [rstu_pkg::BASE_BITS-1:0] radix;
  logic                           in_vld_q;
  logic                           start_q;
  logic [rstu_pkg::CHAR_BITS-1:0] char_q;
  logic                           adv;
  rstu_pkg::char_class_t          cls;

  rstu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .radix_o (radix)
  );

  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q  <= in_i.char_code;
      start_q <= in_i.start_req;
    end
  end

  rstu_char_class u_char_class (
    .char_code_i (char_q),
    .cls_o       (cls)
  );

  rstu_core #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .radix_i    (radix),
    .item_vld_i (in_vld_q),
    .start_i    (start_q),
    .cls_i      (cls),
    .adv_o      (adv),
    .out_o      (out_o)
  );

endmodule
